// ----- rtl/dwg_pkg.sv -----
package dwg_pkg;

    localparam int SINE_TABLE_ADDR_BITS = 10;
    localparam int DAC_BITS             = 16;

    localparam int QSIZE   = 1 << SINE_TABLE_ADDR_BITS;
    localparam int ADDR_W  = SINE_TABLE_ADDR_BITS + 1;
    localparam int ANGLE_W = SINE_TABLE_ADDR_BITS + 2;
    // Widest dividend: a 16-bit residue shifted up by ANGLE_W+1 plus half the divisor.
    localparam int DIV_W   = 16 + ANGLE_W + 2;
    localparam int DVSR_W  = 17;
    localparam int PROD_W  = 46;

    localparam logic [15:0] WORD_MASK = 16'((32'd1 << DAC_BITS) - 32'd1);
    localparam logic [DIV_W-1:0] FULL_SCALE = DIV_W'(64'd1 << DAC_BITS);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        MODE_X    = 3'd0,
        MODE_Y    = 3'd1,
        MODE_RAMP = 3'd2,
        MODE_SINE = 3'd3,
        MODE_TRI  = 3'd4,
        MODE_RCOS = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_X      = 3'd1,
        REG_Y      = 3'd2,
        REG_PERIOD = 3'd3,
        REG_AMP    = 3'd4,
        REG_PHASE  = 3'd5,
        REG_OFFSET = 3'd6
    } t_reg;

    typedef enum logic [2:0] {
        K_FIXED,
        K_ZERO,
        K_LIN,
        K_SIN,
        K_COS
    } t_kind;

    typedef enum logic [1:0] {
        SEL_STEP,
        SEL_MOD,
        SEL_ANG
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_STEP_DIV,
        S_STEP_WAIT,
        S_LMUL,
        S_MOD_DIV,
        S_MOD_WAIT,
        S_MODFIX,
        S_ANG_DIV,
        S_ANG_WAIT,
        S_ADDR,
        S_ROM,
        S_MUL1,
        S_MUL2,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]         wave_mode;
        logic [15:0]        x_word;
        logic [15:0]        y_word;
        logic [15:0]        period_samples;
        logic [15:0]        amplitude;
        logic signed [15:0] phase_shift;
        logic signed [15:0] level_offset;
    } t_cfg;

    typedef struct packed {
        logic     accept;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     lmul;
        logic     modfix;
        logic     addr;
        logic     rom;
        logic     mul1;
        logic     mul2;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_done;
        logic  out_free;
    } t_stat;

    typedef logic [15:0] t_qtab [0:QSIZE];

    // Quarter-wave sine in Q15, from a Q30 Taylor series up to the x^15 term.
    function automatic t_qtab build_qtab();
        t_qtab             tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            q;
        for (int j = 0; j <= QSIZE; j++) begin
            x    = (HALF_PI_Q30 * 64'(j)) >> SINE_TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) != 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                q = 0;
            end else begin
                q = longint'((64'(sum) + 64'd16384) >> 15);
            end
            if (q > 32767) begin
                q = 32767;
            end
            tab[j] = 16'(q);
        end
        return tab;
    endfunction

endpackage

// ----- rtl/dwg_div.sv -----
module dwg_div
    import dwg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic [DIV_W-1:0]  o_quotient,
    output logic [DVSR_W-1:0] o_remainder,
    output logic              o_done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [DVSR_W:0]   trial;
    logic              fits;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of r_q while quotient bits shift in.
    assign trial = {r_rem, r_q[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            if (fits) begin
                r_rem <= DVSR_W'(trial - {1'b0, r_dvsr});
            end else begin
                r_rem <= trial[DVSR_W-1:0];
            end
            r_q <= {r_q[DIV_W-2:0], fits};
        end
    end

    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
    assign o_done      = r_busy && (r_cnt == '0);

endmodule

// ----- rtl/dwg_datapath.sv -----
module dwg_datapath
    import dwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic        i_restart,
    input  logic        i_stall,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [15:0] o_dac_word,
    output logic        o_period_end
);

    localparam t_qtab QTAB = build_qtab();

    logic [16:0]         r_pos;
    logic                r_desc;
    logic                r_restart;
    logic signed [17:0]  r_t;
    logic [16:0]         r_s;
    logic [15:0]         r_k;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_neg;
    logic [15:0]         r_rom_q;
    logic [29:0]         r_w;
    logic [PROD_W-1:0]   r_prod;
    logic                r_valid;
    logic [15:0]         r_word;
    logic                r_end;

    t_kind               kind;
    t_mode               mode;
    logic [16:0]         n;
    logic [15:0]         d;
    logic [16:0]         pos0;
    logic                desc0;
    logic [16:0]         pos1;
    logic                desc1;

    logic [DIV_W-1:0]    div_dividend;
    logic [DVSR_W-1:0]   div_divisor;
    logic [DIV_W-1:0]    div_q;
    logic [DVSR_W-1:0]   div_rem;
    logic                div_done;
    logic [16:0]         t_abs;

    logic [15:0]         u;
    logic [ANGLE_W-1:0]  angle;
    logic [SINE_TABLE_ADDR_BITS-1:0] j;

    logic signed [15:0]  trig;
    logic signed [32:0]  sin_prod;
    logic signed [31:0]  cos_term;
    logic signed [31:0]  w_full;
    logic [PROD_W-1:0]   cos_prod;

    logic [30:0]         sin_round;
    logic [PROD_W-1:0]   cos_round;
    logic [15:0]         word;
    logic [17:0]         lin_next;
    logic [16:0]         pos_next;
    logic                desc_next;
    logic                end_next;

    assign mode = t_mode'(i_cfg.wave_mode);
    assign n    = {1'b0, i_cfg.period_samples};
    assign d    = (mode == MODE_RCOS) ? i_cfg.period_samples - 16'd1
                                      : i_cfg.period_samples;

    always_comb begin
        if (mode < MODE_RAMP || mode > MODE_RCOS) begin
            kind = K_FIXED;
        end else if (n == '0 || (mode == MODE_RCOS && n == 17'd1)) begin
            kind = K_ZERO;
        end else if (mode == MODE_RAMP || mode == MODE_TRI) begin
            kind = K_LIN;
        end else if (mode == MODE_SINE) begin
            kind = K_SIN;
        end else begin
            kind = K_COS;
        end
    end

    // Restart and stale-position handling before the sample is evaluated.
    always_comb begin
        pos0  = r_restart ? '0 : r_pos;
        desc0 = (r_restart || mode != MODE_TRI) ? 1'b0 : r_desc;
        pos1  = pos0;
        desc1 = desc0;
        case (kind)
            K_LIN: begin
                if (desc0 && (pos0 == '0 || pos0 >= n)) begin
                    desc1 = 1'b0;
                    pos1  = '0;
                end
                if (!desc1 && pos1 >= n) begin
                    pos1 = '0;
                end
            end
            K_SIN, K_COS: begin
                desc1 = 1'b0;
                if (pos0 >= n) begin
                    pos1 = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign t_abs = r_t[17] ? 17'(-r_t) : r_t[16:0];

    always_comb begin
        case (i_cmd.div_sel)
            SEL_STEP: begin
                div_dividend = FULL_SCALE;
                div_divisor  = n;
            end
            SEL_MOD: begin
                div_dividend = DIV_W'(t_abs);
                div_divisor  = {1'b0, d};
            end
            default: begin
                div_dividend = (DIV_W'(r_k) << (ANGLE_W + 1)) + DIV_W'(d);
                div_divisor  = {d, 1'b0};
            end
        endcase
    end

    dwg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_q),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    assign u     = div_rem[15:0];
    assign angle = (kind == K_COS) ? div_q[ANGLE_W-1:0] + ANGLE_W'(QSIZE)
                                   : div_q[ANGLE_W-1:0];
    assign j     = angle[SINE_TABLE_ADDR_BITS-1:0];

    assign trig     = r_neg ? -$signed(r_rom_q) : $signed(r_rom_q);
    assign sin_prod = $signed({1'b0, i_cfg.amplitude}) * trig;
    assign cos_term = $signed(16'sd13107) * trig;
    assign w_full   = 32'sd536870912 - cos_term;
    assign cos_prod = i_cfg.amplitude * r_w;

    assign sin_round = r_prod[30:0] + 31'd16384;
    assign cos_round = r_prod + (PROD_W'(1) << 29);

    always_comb begin
        case (kind)
            K_FIXED: word = (mode == MODE_Y) ? i_cfg.y_word : i_cfg.x_word;
            K_ZERO:  word = i_cfg.level_offset;
            K_LIN:   word = r_prod[15:0] + i_cfg.level_offset;
            K_SIN:   word = sin_round[30:15] + i_cfg.amplitude + i_cfg.level_offset;
            default: word = cos_round[45:30] + i_cfg.amplitude + i_cfg.level_offset;
        endcase
    end

    assign lin_next = {1'b0, r_pos} + {1'b0, r_s};

    always_comb begin
        pos_next  = '0;
        desc_next = 1'b0;
        end_next  = 1'b1;
        case (kind)
            K_LIN: begin
                if (!r_desc) begin
                    if (lin_next < {1'b0, n}) begin
                        pos_next = lin_next[16:0];
                        end_next = 1'b0;
                    end else if (mode == MODE_TRI && n > 17'd1) begin
                        desc_next = 1'b1;
                        pos_next  = n - 17'd1;
                        end_next  = 1'b0;
                    end
                end else if (r_pos > r_s) begin
                    desc_next = 1'b1;
                    pos_next  = r_pos - r_s;
                    end_next  = 1'b0;
                end
            end
            K_SIN, K_COS: begin
                if (r_pos + 17'd1 < n) begin
                    pos_next = r_pos + 17'd1;
                    end_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_desc  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_pos  <= pos1;
                r_desc <= desc1;
            end else if (i_cmd.fin) begin
                r_pos  <= pos_next;
                r_desc <= desc_next;
            end
            if (i_cmd.fin) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_restart <= i_restart;
        end
        if (i_cmd.prep) begin
            r_t <= $signed({1'b0, pos1}) + 18'(i_cfg.phase_shift);
        end
        if (i_cmd.lmul) begin
            r_s    <= div_q[16:0];
            r_prod <= {30'b0, div_q[15:0] * r_t[15:0]};
        end
        if (i_cmd.modfix) begin
            r_k <= (r_t[17] && u != '0) ? d - u : u;
        end
        if (i_cmd.addr) begin
            r_addr <= angle[SINE_TABLE_ADDR_BITS]
                      ? ADDR_W'(QSIZE) - ADDR_W'(j) : ADDR_W'(j);
            r_neg  <= angle[ANGLE_W-1];
        end
        if (i_cmd.rom) begin
            r_rom_q <= QTAB[r_addr];
        end
        if (i_cmd.mul1) begin
            if (kind == K_SIN) begin
                r_prod <= PROD_W'(sin_prod);
            end else begin
                r_w <= w_full[29:0];
            end
        end
        if (i_cmd.mul2) begin
            r_prod <= cos_prod;
        end
        if (i_cmd.fin) begin
            r_word <= word & WORD_MASK;
            r_end  <= end_next;
        end
    end

    assign o_stat.kind     = kind;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_valid || !i_stall;

    assign o_valid      = r_valid;
    assign o_dac_word   = r_word;
    assign o_period_end = r_end;

endmodule

// ----- rtl/dwg_ctrl.sv -----
module dwg_ctrl
    import dwg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_valid) n_state = S_PREP;
            S_PREP: begin
                case (i_stat.kind)
                    K_LIN:        n_state = S_STEP_DIV;
                    K_SIN, K_COS: n_state = S_MOD_DIV;
                    default:      n_state = S_FIN;
                endcase
            end
            S_STEP_DIV:  n_state = S_STEP_WAIT;
            S_STEP_WAIT: if (i_stat.div_done) n_state = S_LMUL;
            S_LMUL:      n_state = S_FIN;
            S_MOD_DIV:   n_state = S_MOD_WAIT;
            S_MOD_WAIT:  if (i_stat.div_done) n_state = S_MODFIX;
            S_MODFIX:    n_state = S_ANG_DIV;
            S_ANG_DIV:   n_state = S_ANG_WAIT;
            S_ANG_WAIT:  if (i_stat.div_done) n_state = S_ADDR;
            S_ADDR:      n_state = S_ROM;
            S_ROM:       n_state = S_MUL1;
            S_MUL1:      n_state = (i_stat.kind == K_COS) ? S_MUL2 : S_FIN;
            S_MUL2:      n_state = S_FIN;
            S_FIN:       if (i_stat.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = SEL_STEP;
        unique case (r_state)
            S_IDLE:     o_cmd.accept = i_valid;
            S_PREP:     o_cmd.prep = 1'b1;
            S_STEP_DIV: o_cmd.div_start = 1'b1;
            S_LMUL:     o_cmd.lmul = 1'b1;
            S_MOD_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_MOD;
            end
            S_MODFIX:   o_cmd.modfix = 1'b1;
            S_ANG_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_ANG;
            end
            S_ADDR:     o_cmd.addr = 1'b1;
            S_ROM:      o_cmd.rom = 1'b1;
            S_MUL1:     o_cmd.mul1 = 1'b1;
            S_MUL2:     o_cmd.mul2 = 1'b1;
            S_FIN:      o_cmd.fin = i_stat.out_free;
            default: begin
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/dac_waveform_generator_core.sv -----
// Each accepted request walks the controller states to the final one: fixed words and zero
// periods skip the arithmetic, ramp and triangle divide once, sine shapes divide twice and
// raised cosine adds a second multiply. No new request is taken until the current one is
// done; a shared serial divider (one quotient bit per cycle) does all the dividing.
// A finished word waits in an output register while the next request is taken.
// Synchronous active-low reset restores the register defaults and position zero, rising.
module dac_waveform_generator_core
    import dwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_dac_word,
    output logic        o_period_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    t_reg  reg_idx;
    logic  wr_en;

    assign reg_idx = t_reg'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_mode      <= MODE_X;
            r_cfg.x_word         <= '0;
            r_cfg.y_word         <= '0;
            r_cfg.period_samples <= 16'd8192;
            r_cfg.amplitude      <= 16'd32767;
            r_cfg.phase_shift    <= '0;
            r_cfg.level_offset   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:   r_cfg.wave_mode      <= pwdata[2:0];
                REG_X:      r_cfg.x_word         <= pwdata[15:0];
                REG_Y:      r_cfg.y_word         <= pwdata[15:0];
                REG_PERIOD: r_cfg.period_samples <= pwdata[15:0];
                REG_AMP:    r_cfg.amplitude      <= pwdata[15:0];
                REG_PHASE:  r_cfg.phase_shift    <= pwdata[15:0];
                REG_OFFSET: r_cfg.level_offset   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:   prdata = {29'b0, r_cfg.wave_mode};
            REG_X:      prdata = {16'b0, r_cfg.x_word};
            REG_Y:      prdata = {16'b0, r_cfg.y_word};
            REG_PERIOD: prdata = {16'b0, r_cfg.period_samples};
            REG_AMP:    prdata = {16'b0, r_cfg.amplitude};
            REG_PHASE:  prdata = {16'b0, r_cfg.phase_shift};
            REG_OFFSET: prdata = {16'b0, r_cfg.level_offset};
            default:    prdata = '0;
        endcase
    end

    dwg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    dwg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .i_restart    (i_restart),
        .i_stall      (i_stall),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_dac_word   (o_dac_word),
        .o_period_end (o_period_end)
    );

endmodule
